### src/packet_class_port_scan_detector_assert.svh
// Assertion macros for the packet classifier and port scan detector.
`ifndef PACKET_CLASS_PORT_SCAN_DETECTOR_ASSERT_SVH
`define PACKET_CLASS_PORT_SCAN_DETECTOR_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PSD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psd assertion failed");

// Next-cycle implication, off during reset.
`define PSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psd assertion failed");

`endif

### src/psd_pkg.sv
// Shared types and constants of the packet classifier and port scan detector.
package psd_pkg;

  localparam int SOURCES_DEF = 64;
  localparam int PORTS_DEF   = 16;

  localparam logic [15:0] ETH_IPV4         = 16'h0800;
  localparam logic [15:0] ETH_ARP          = 16'h0806;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [15:0] PORT_DNS         = 16'd53;
  localparam logic [15:0] PORT_DHCP_SERVER = 16'd67;
  localparam logic [15:0] PORT_DHCP_CLIENT = 16'd68;
  localparam logic [3:0]  THRESHOLD_RESET  = 4'd10;
  localparam logic [4:0]  PORTS_FIELD_MAX  = 5'd31;

  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_TCP   = 2'd1;
  localparam logic [1:0] CLASS_UDP   = 2'd2;
  localparam logic [1:0] CLASS_ARP   = 2'd3;

  typedef struct packed {
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } packet_t;

  typedef struct packed {
    logic [1:0] packet_class;
    logic       dns_flag;
    logic       dhcp_flag;
    logic       scan_alert;
    logic [4:0] distinct_ports;
    logic       not_tracked;
  } result_t;

endpackage

### src/psd_cell.sv
// One source table cell: holds an entry and passes the search token to its neighbor.
module psd_cell #(
  parameter int SOURCES          = psd_pkg::SOURCES_DEF,
  parameter int PORTS_PER_SOURCE = psd_pkg::PORTS_DEF,
  parameter int INDEX            = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [31:0]                          key,
  input  logic [$clog2(SOURCES+1)-1:0]         fill,
  input  logic                                 wr_en,
  input  logic [$clog2(SOURCES)-1:0]           wr_idx,
  input  logic [31:0]                          wr_source,
  input  logic [$clog2(PORTS_PER_SOURCE+1)-1:0] wr_count,
  input  logic                                 hit_in,
  input  logic [$clog2(SOURCES)-1:0]           idx_in,
  input  logic [$clog2(PORTS_PER_SOURCE+1)-1:0] count_in,
  output logic                                 hit_out,
  output logic [$clog2(SOURCES)-1:0]           idx_out,
  output logic [$clog2(PORTS_PER_SOURCE+1)-1:0] count_out
);

  localparam int IDX_W  = $clog2(SOURCES);
  localparam int FILL_W = $clog2(SOURCES + 1);
  localparam int CNT_W  = $clog2(PORTS_PER_SOURCE + 1);

  logic [31:0]      source;
  logic [CNT_W-1:0] count;
  logic             match;

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == IDX_W'(INDEX)) begin
      source <= wr_source;
      count  <= wr_count;
    end
  end

  // Entries are allocated in order, so the fill count marks which are live.
  assign match = (FILL_W'(INDEX) < fill) && (source == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_out <= 1'b0;
    end else begin
      hit_out <= hit_in | match;
    end
  end

  always_ff @(posedge clk) begin
    if (!hit_in && match) begin
      idx_out   <= IDX_W'(INDEX);
      count_out <= count;
    end else begin
      idx_out   <= idx_in;
      count_out <= count_in;
    end
  end

endmodule

### src/packet_class_port_scan_detector.sv
// Top level: packet classifier with a per-source distinct TCP port counter.
//
// Each transaction is one packet's header fields, taken when start is high and
// busy is low; its result appears on result for exactly one cycle with done high,
// and the receiver cannot stall it. Non-TCP packets finish in the cycle after they
// are accepted and busy never rises. For a TCP packet the search token walks the
// row of SOURCES source cells one cell a cycle, then the port list memory is read
// one port a cycle through its single read port, and then the entry is updated.
// The next packet may be started in the cycle that done is high. The alert
// threshold is written through cfg_write and cfg_data.
`include "packet_class_port_scan_detector_assert.svh"

module packet_class_port_scan_detector #(
  parameter int SOURCES          = psd_pkg::SOURCES_DEF,
  parameter int PORTS_PER_SOURCE = psd_pkg::PORTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  psd_pkg::packet_t packet,
  output logic             done,
  output psd_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [3:0]       cfg_data
);

  localparam int IDX_W  = $clog2(SOURCES);
  localparam int FILL_W = $clog2(SOURCES + 1);
  localparam int CNT_W  = $clog2(PORTS_PER_SOURCE + 1);
  localparam int DEPTH  = SOURCES * PORTS_PER_SOURCE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]        state;
  logic [3:0]        threshold;
  logic [31:0]       key;
  logic [15:0]       dport;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] timer;
  logic [IDX_W-1:0]  ent;
  logic [CNT_W-1:0]  n;
  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  issue_k;
  logic              pend;
  logic              found;
  logic              tracked;

  logic              ipv4_in;
  logic              tcp_in;
  logic              udp_in;
  logic [1:0]        class_in;
  logic [IDX_W-1:0]  ent_sel;
  logic [ADDR_W-1:0] ent_base;
  logic [CNT_W-1:0]  n_next;
  logic [CMP_W-1:0]  n_wide;
  logic              append;

  logic              mem_re;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       rd_data;
  logic [15:0]       port_mem [DEPTH];

  logic              cell_we;
  logic              hit_c [SOURCES+1];
  logic [IDX_W-1:0]  idx_c [SOURCES+1];
  logic [CNT_W-1:0]  cnt_c [SOURCES+1];

  // Classification of the incoming packet.
  assign ipv4_in = (packet.eth_type == psd_pkg::ETH_IPV4);
  assign tcp_in  = ipv4_in && (packet.ip_protocol == psd_pkg::PROTO_TCP);
  assign udp_in  = ipv4_in && (packet.ip_protocol == psd_pkg::PROTO_UDP);

  always_comb begin
    if (tcp_in) begin
      class_in = psd_pkg::CLASS_TCP;
    end else if (udp_in) begin
      class_in = psd_pkg::CLASS_UDP;
    end else if (packet.eth_type == psd_pkg::ETH_ARP) begin
      class_in = psd_pkg::CLASS_ARP;
    end else begin
      class_in = psd_pkg::CLASS_OTHER;
    end
  end

  assign busy = (state != S_IDLE);

  // Row of source cells; the token enters empty at the left end.
  assign hit_c[0] = 1'b0;
  assign idx_c[0] = '0;
  assign cnt_c[0] = '0;

  for (genvar g = 0; g < SOURCES; g++) begin : g_cell
    psd_cell #(
      .SOURCES          (SOURCES),
      .PORTS_PER_SOURCE (PORTS_PER_SOURCE),
      .INDEX            (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .fill      (fill),
      .wr_en     (cell_we),
      .wr_idx    (ent),
      .wr_source (key),
      .wr_count  (n_next),
      .hit_in    (hit_c[g]),
      .idx_in    (idx_c[g]),
      .count_in  (cnt_c[g]),
      .hit_out   (hit_c[g+1]),
      .idx_out   (idx_c[g+1]),
      .count_out (cnt_c[g+1])
    );
  end

  // Entry chosen at the end of the search: the hit, or the next free one.
  assign ent_sel  = hit_c[SOURCES] ? idx_c[SOURCES] : fill[IDX_W-1:0];
  assign ent_base = ADDR_W'(ent_sel) * ADDR_W'(PORTS_PER_SOURCE);

  assign append = tracked && !found && (n != CNT_W'(PORTS_PER_SOURCE));
  assign n_next = append ? n + CNT_W'(1) : n;
  assign n_wide = CMP_W'(n_next);

  assign mem_re    = (state == S_SCAN) && (issue_k != n);
  assign mem_raddr = base + ADDR_W'(issue_k);
  assign mem_we    = (state == S_UPDATE) && append;
  assign mem_waddr = base + ADDR_W'(n);
  assign cell_we   = (state == S_UPDATE) && tracked;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      port_mem[mem_waddr] <= dport;
    end
    if (mem_re) begin
      rd_data <= port_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= psd_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key   <= packet.source_address;
            dport <= packet.dest_port;
            timer <= '0;
            if (tcp_in) begin
              state <= S_SEARCH;
            end else begin
              done                  <= 1'b1;
              result.packet_class   <= class_in;
              result.dns_flag       <= udp_in &&
                                       (packet.dest_port == psd_pkg::PORT_DNS ||
                                        packet.source_port == psd_pkg::PORT_DNS);
              result.dhcp_flag      <= udp_in &&
                                       (packet.dest_port == psd_pkg::PORT_DHCP_SERVER ||
                                        packet.dest_port == psd_pkg::PORT_DHCP_CLIENT);
              result.scan_alert     <= 1'b0;
              result.distinct_ports <= '0;
              result.not_tracked    <= 1'b0;
            end
          end
        end
        S_SEARCH: begin
          // Wait for the token to leave the last cell.
          if (timer == FILL_W'(SOURCES)) begin
            base    <= ent_base;
            ent     <= ent_sel;
            issue_k <= '0;
            pend    <= 1'b0;
            found   <= 1'b0;
            state   <= S_SCAN;
            if (hit_c[SOURCES]) begin
              tracked <= 1'b1;
              n       <= cnt_c[SOURCES];
            end else if (fill != FILL_W'(SOURCES)) begin
              tracked <= 1'b1;
              n       <= '0;
              fill    <= fill + FILL_W'(1);
            end else begin
              tracked <= 1'b0;
              n       <= '0;
            end
          end else begin
            timer <= timer + FILL_W'(1);
          end
        end
        S_SCAN: begin
          // Issue one read a cycle; compare the data in the cycle after its read.
          if (issue_k != n) begin
            issue_k <= issue_k + CNT_W'(1);
          end
          pend <= mem_re;
          if (pend && rd_data == dport) begin
            found <= 1'b1;
          end
          if (issue_k == n && !pend) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          done                  <= 1'b1;
          result.packet_class   <= psd_pkg::CLASS_TCP;
          result.dns_flag       <= 1'b0;
          result.dhcp_flag      <= 1'b0;
          result.scan_alert     <= tracked && (n_wide > CMP_W'(threshold));
          result.not_tracked    <= !tracked;
          if (!tracked) begin
            result.distinct_ports <= '0;
          end else if (n_wide > CMP_W'(psd_pkg::PORTS_FIELD_MAX)) begin
            result.distinct_ports <= psd_pkg::PORTS_FIELD_MAX;
          end else begin
            result.distinct_ports <= n_wide[4:0];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PSD_ASSERT_IMPLIES(a_fill_bound, clk, rst, 1'b1, fill <= FILL_W'(SOURCES))
  `PSD_ASSERT_IMPLIES(a_untracked_full, clk, rst, done && result.not_tracked, fill == FILL_W'(SOURCES))
  `PSD_ASSERT_NEXT(a_tcp_goes_busy, clk, rst, start && !busy && tcp_in, busy && !done)
  `PSD_ASSERT_IMPLIES(a_scan_bound, clk, rst, state == S_SCAN, issue_k <= n)

endmodule

### tb/psd_result_checker.sv
// Checker for the port scan detector: predicts each result and compares it with the block.
module psd_result_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  psd_pkg::packet_t packet,
  input  logic             done,
  input  psd_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [3:0]       cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SOURCES = psd_pkg::SOURCES_DEF;
  localparam int PORTS   = psd_pkg::PORTS_DEF;

  // Shadow copy of the source table and the threshold
  logic [3:0]  threshold;
  bit          src_valid [SOURCES];
  logic [31:0] src_addr [SOURCES];
  int unsigned port_count [SOURCES];
  logic [15:0] port_list [SOURCES][PORTS];
  int          next_free;

  psd_pkg::result_t expected_results [$];
  int               fail_count = 0;

  function automatic psd_pkg::result_t classify_and_count(psd_pkg::packet_t p);
    psd_pkg::result_t r;
    int      slot;
    int      n;
    bit      seen;
    r = '0;
    if (p.eth_type == psd_pkg::ETH_IPV4 && p.ip_protocol == psd_pkg::PROTO_TCP) begin
      r.packet_class = psd_pkg::CLASS_TCP;
      slot = -1;
      for (int i = 0; i < SOURCES; i++)
        if (slot < 0 && src_valid[i] && src_addr[i] == p.source_address) slot = i;
      // allocate in order while the table has room
      if (slot < 0 && next_free < SOURCES) begin
        slot = next_free;
        src_valid[slot]  = 1'b1;
        src_addr[slot]   = p.source_address;
        port_count[slot] = 0;
        next_free++;
      end
      if (slot < 0) begin
        r.not_tracked = 1'b1;
      end else begin
        n    = port_count[slot];
        seen = 1'b0;
        for (int k = 0; k < n; k++)
          if (port_list[slot][k] == p.dest_port) seen = 1'b1;
        // drop new ports once the list is full
        if (!seen && n < PORTS) begin
          port_list[slot][n] = p.dest_port;
          port_count[slot]   = n + 1;
        end
        r.scan_alert     = port_count[slot] > threshold;
        r.distinct_ports = (port_count[slot] > 31) ? psd_pkg::PORTS_FIELD_MAX
                                                   : 5'(port_count[slot]);
      end
    end else if (p.eth_type == psd_pkg::ETH_IPV4 && p.ip_protocol == psd_pkg::PROTO_UDP) begin
      r.packet_class = psd_pkg::CLASS_UDP;
      r.dns_flag     = (p.dest_port == psd_pkg::PORT_DNS) ||
                       (p.source_port == psd_pkg::PORT_DNS);
      r.dhcp_flag    = (p.dest_port == psd_pkg::PORT_DHCP_SERVER) ||
                       (p.dest_port == psd_pkg::PORT_DHCP_CLIENT);
    end else if (p.eth_type == psd_pkg::ETH_ARP) begin
      r.packet_class = psd_pkg::CLASS_ARP;
    end else begin
      r.packet_class = psd_pkg::CLASS_OTHER;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    psd_pkg::result_t want;
    if (rst) begin
      threshold = psd_pkg::THRESHOLD_RESET;
      for (int i = 0; i < SOURCES; i++) begin
        src_valid[i]  = 1'b0;
        port_count[i] = 0;
      end
      next_free = 0;
      expected_results.delete();
    end else begin
      // retire the finished transaction before taking the next one
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result: unexpected transaction, nothing pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("packet_class", want.packet_class, result.packet_class);
          check_field("dns_flag", want.dns_flag, result.dns_flag);
          check_field("dhcp_flag", want.dhcp_flag, result.dhcp_flag);
          check_field("scan_alert", want.scan_alert, result.scan_alert);
          check_field("distinct_ports", want.distinct_ports, result.distinct_ports);
          check_field("not_tracked", want.not_tracked, result.not_tracked);
        end
      end
      if (cfg_write) threshold = cfg_data;
      if (start && !busy) begin
        want = classify_and_count(packet);
        expected_results = {expected_results, want};
      end
    end
    errors  <= fail_count;
    pending <= expected_results.size();
  end

endmodule

### tb/tb_packet_class_port_scan_detector.sv
// Testbench top for the port scan detector: drives packets and thresholds, gives the verdict.
module tb_packet_class_port_scan_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOT_SOURCES  = 8;
  localparam int WARM_SOURCES = 80;
  localparam int HOT_PORTS    = 24;
  localparam int PHASE_ITEMS  = 65;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  psd_pkg::packet_t packet;
  logic             done;
  psd_pkg::result_t result;
  logic             cfg_write;
  logic [3:0]       cfg_data;
  int               errors;
  int               pending;

  logic [31:0] hot_sources [HOT_SOURCES];
  logic [31:0] warm_sources [WARM_SOURCES];
  logic [15:0] hot_ports [HOT_PORTS];

  always #6 clk = ~clk;

  packet_class_port_scan_detector dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .packet    (packet),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  psd_result_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .packet    (packet),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic psd_pkg::packet_t make_packet(logic [15:0] eth, logic [7:0] proto,
                                                   logic [31:0] src, logic [15:0] sport,
                                                   logic [15:0] dport);
    psd_pkg::packet_t p;
    p.eth_type       = eth;
    p.ip_protocol    = proto;
    p.source_address = src;
    p.source_port    = sport;
    p.dest_port      = dport;
    return p;
  endfunction

  // Half TCP, mostly from a few busy sources, so port lists fill and the table runs out
  function automatic psd_pkg::packet_t random_packet();
    psd_pkg::packet_t p;
    int      kind;
    int      pick;
    bit      hot;
    p    = make_packet(16'($urandom), 8'($urandom), $urandom, 16'($urandom), 16'($urandom));
    kind = $urandom_range(0, 99);
    hot  = 1'b0;
    if (kind < 50) begin
      p.eth_type    = psd_pkg::ETH_IPV4;
      p.ip_protocol = psd_pkg::PROTO_TCP;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        p.source_address = hot_sources[$urandom_range(0, HOT_SOURCES - 1)];
        hot = 1'b1;
      end else if (pick < 80) begin
        p.source_address = warm_sources[$urandom_range(0, WARM_SOURCES - 1)];
      end
      if (hot || $urandom_range(0, 1))
        p.dest_port = hot_ports[$urandom_range(0, HOT_PORTS - 1)];
    end else if (kind < 70) begin
      p.eth_type    = psd_pkg::ETH_IPV4;
      p.ip_protocol = psd_pkg::PROTO_UDP;
      case ($urandom_range(0, 9))
        0: p.source_port = psd_pkg::PORT_DNS;
        1: p.source_port = psd_pkg::PORT_DHCP_SERVER;
        2: p.source_port = psd_pkg::PORT_DHCP_CLIENT;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0: p.dest_port = psd_pkg::PORT_DNS;
        1: p.dest_port = psd_pkg::PORT_DHCP_SERVER;
        2: p.dest_port = psd_pkg::PORT_DHCP_CLIENT;
        3: p.dest_port = psd_pkg::PORT_DHCP_SERVER - 16'd1;
        4: p.dest_port = psd_pkg::PORT_DHCP_CLIENT + 16'd1;
        default: ;
      endcase
    end else if (kind < 78) begin
      p.eth_type = psd_pkg::ETH_ARP;
    end else if (kind < 88) begin
      p.eth_type = psd_pkg::ETH_IPV4;
    end
    return p;
  endfunction

  // Hold start high until the block takes the transaction
  task automatic send_packet(psd_pkg::packet_t p, bit allow_idle);
    if (allow_idle && $urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 2)) @(negedge clk) begin
        start  <= 1'b0;
        packet <= random_packet();
      end
    end
    @(negedge clk);
    start  <= 1'b1;
    packet <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_threshold(logic [3:0] value);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [3:0] phase_threshold [6];
    rst       = 1'b1;
    start     = 1'b0;
    packet    = '0;
    cfg_write = 1'b0;
    cfg_data  = 4'd0;

    foreach (hot_sources[i]) hot_sources[i] = $urandom;
    foreach (warm_sources[i]) warm_sources[i] = $urandom;
    foreach (hot_ports[i]) hot_ports[i] = 16'($urandom);

    phase_threshold[0] = 4'd0;
    phase_threshold[1] = 4'd15;
    phase_threshold[2] = 4'($urandom_range(0, 15));
    phase_threshold[3] = 4'd14;
    phase_threshold[4] = 4'd1;
    phase_threshold[5] = 4'($urandom_range(0, 15));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Classes and flags at the field extremes, reset threshold
    send_packet(make_packet(psd_pkg::ETH_ARP, 8'h00, 32'h0, 16'h0, 16'h0), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, 8'h00, 32'h0, 16'h0, 16'h0), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF),
                1'b1);
    send_packet(make_packet(16'hFFFF, psd_pkg::PROTO_TCP, 32'h1, 16'h1, 16'h1), 1'b1);
    send_packet(make_packet(16'h0000, psd_pkg::PROTO_UDP, 32'h2, psd_pkg::PORT_DNS,
                            psd_pkg::PORT_DNS), 1'b1);
    send_packet(make_packet(16'h86DD, psd_pkg::PROTO_TCP, 32'h3, 16'h0, 16'h0), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_ARP, psd_pkg::PROTO_TCP, 32'h4, 16'h0, 16'h0),
                1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_UDP, 32'h5, 16'h1000,
                            psd_pkg::PORT_DNS), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_UDP, 32'h6, psd_pkg::PORT_DNS,
                            16'h0), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_UDP, 32'h7, psd_pkg::PORT_DNS,
                            psd_pkg::PORT_DNS), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_UDP, 32'h8, 16'h0,
                            psd_pkg::PORT_DHCP_SERVER), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_UDP, 32'h9, 16'hFFFF,
                            psd_pkg::PORT_DHCP_CLIENT), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_UDP, 32'hA,
                            psd_pkg::PORT_DHCP_SERVER, 16'd69), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_UDP, 32'hB, 16'h0, 16'd66),
                1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_TCP, 32'h0, 16'h0, 16'h0),
                1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_TCP, 32'h0, 16'hFFFF, 16'h0),
                1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_TCP, 32'h0, 16'h0, 16'hFFFF),
                1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_TCP, 32'hFFFF_FFFF,
                            psd_pkg::PORT_DNS, psd_pkg::PORT_DHCP_SERVER), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_TCP, 32'hFFFF_FFFF, 16'h0,
                            psd_pkg::PORT_DNS), 1'b1);
    send_packet(make_packet(psd_pkg::ETH_IPV4, psd_pkg::PROTO_TCP, 32'h0, 16'h0, 16'h0),
                1'b1);

    // Random traffic, one threshold per phase; the second phase never idles
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(phase_threshold[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_packet(random_packet(), ph != 1);
    end

    drain();
    repeat (90) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
